>>> rtl/core/sparse_block_map_reader_macros.svh
// assertion macros shared by the checker
`ifndef SPARSE_BLOCK_MAP_READER_MACROS_SVH
`define SPARSE_BLOCK_MAP_READER_MACROS_SVH

// same-cycle implication, sampled on the block clock
`define SBMR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the block clock
`define SBMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sbmr_pkg.sv
`timescale 1ns / 1ps
package sbmr_pkg;

  // map geometry
  localparam int MAP_DEPTH_DEF = 1024;
  localparam int ENTRY_W       = 16;
  localparam int INDEX_W       = 10;

  // register widths and limits
  localparam int SHIFT_W       = 5;
  localparam int ENTRIES_W     = 11;
  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd15;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd30;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd21;

  // register indexes (paddr bit 2)
  localparam logic REG_BLOCK_SHIFT = 1'b0;
  localparam logic REG_MAP_ENTRIES = 1'b1;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // payload widths
  localparam int DISC_W   = 34;
  localparam int LEN_W    = 21;
  localparam int FOFF_W   = 46;
  localparam int POS_W    = 35;
  localparam int BLK_W    = POS_W - 15;
  localparam int WITHIN_W = 30;
  localparam int SPAN_W   = WITHIN_W + 1;
  localparam logic [LEN_W-1:0] MAX_LEN = 21'd1048576;

  // controller to datapath
  typedef struct packed {
    logic load;   // write one map entry
    logic read;   // start a read request
    logic step;   // cut one chunk and issue its map read
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic len_zero;  // incoming request length is zero
    logic last;      // chunk being cut ends the request
    logic s1_valid;  // a chunk waits for its map data
  } dp_stat_t;

endpackage

>>> rtl/core/sbmr_ram.sv
`timescale 1ns / 1ps
module sbmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/sbmr_ctrl.sv
`timescale 1ns / 1ps
module sbmr_ctrl import sbmr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     action_i,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o,
  output logic     busy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic accept;

  // busy while chunks are cut or one waits for map data
  assign busy   = (state_q == ST_RUN) || stat_i.s1_valid;
  assign accept = start && !busy;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ACT_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (!stat_i.len_zero) begin
            cmd_o.read = 1'b1;
            state_d    = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/sbmr_dpath.sv
`timescale 1ns / 1ps
module sbmr_dpath import sbmr_pkg::*; #(
  parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_cmd_t             cmd_i,
  output dp_stat_t             stat_o,
  input  logic [SHIFT_W-1:0]   block_shift_i,
  input  logic [ENTRIES_W-1:0] map_entries_i,
  input  logic [INDEX_W-1:0]   entry_index_i,
  input  logic [ENTRY_W-1:0]   entry_value_i,
  input  logic [DISC_W-1:0]    disc_offset_i,
  input  logic [LEN_W-1:0]     request_length_i,
  output logic                 result_valid_o,
  output logic [FOFF_W-1:0]    file_offset_o,
  output logic [LEN_W-1:0]     chunk_length_o,
  output logic                 zero_fill_o,
  output logic                 last_chunk_o
);

  localparam int AW = $clog2(MAP_DEPTH);

  logic [POS_W-1:0]    pos_q, pos_d;
  logic [LEN_W-1:0]    rem_q, rem_d;
  logic [BLK_W-1:0]    blk;
  logic [SPAN_W-1:0]   bsize, span;
  logic [WITHIN_W-1:0] blk_off;
  logic [LEN_W-1:0]    chunk;
  logic                last;
  logic                hit;
  logic [LEN_W-1:0]    len_sat;

  logic [WITHIN_W-1:0] blk_off_q;
  logic [LEN_W-1:0]    len_q;
  logic                last_q;
  logic                hit_q;
  logic                s1_valid_q;

  logic                we;
  logic [ENTRY_W-1:0]  entry;
  logic                mapped;
  logic [FOFF_W-1:0]   foff;

  // cut the current chunk at the block boundary
  assign blk     = BLK_W'(pos_q >> block_shift_i);
  assign bsize   = SPAN_W'(1) << block_shift_i;
  assign blk_off = pos_q[WITHIN_W-1:0] & WITHIN_W'(bsize - SPAN_W'(1));
  assign span    = bsize - SPAN_W'(blk_off);
  assign last    = SPAN_W'(rem_q) <= span;
  assign chunk   = last ? rem_q : LEN_W'(span);
  assign hit     = blk < BLK_W'(map_entries_i);

  // saturate the request length
  assign len_sat = (request_length_i > MAX_LEN) ? MAX_LEN : request_length_i;

  assign stat_o.len_zero = (request_length_i == '0);
  assign stat_o.last     = last;
  assign stat_o.s1_valid = s1_valid_q;

  // map writes for slots inside the map
  assign we = cmd_i.load && (32'(entry_index_i) < 32'(MAP_DEPTH));

  sbmr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(AW'(entry_index_i)),
    .wdata_i(entry_value_i),
    .raddr_i(AW'(blk)),
    .rdata_o(entry)
  );

  // position and remaining length
  always_comb begin
    pos_d = pos_q;
    rem_d = rem_q;
    if (cmd_i.read) begin
      pos_d = POS_W'(disc_offset_i);
      rem_d = len_sat;
    end else if (cmd_i.step) begin
      pos_d = pos_q + POS_W'(chunk);
      rem_d = rem_q - chunk;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    rem_q <= rem_d;
  end

  // chunk fields waiting for map data
  always_ff @(posedge clk_i) begin
    blk_off_q <= blk_off;
    len_q     <= chunk;
    last_q    <= last;
    hit_q     <= hit;
  end

  // translate with the entry read back
  assign mapped = hit_q && (entry != '0);
  assign foff   = mapped ? ((FOFF_W'(entry) << block_shift_i) + FOFF_W'(blk_off_q))
                         : '0;

  always_ff @(posedge clk_i) begin
    file_offset_o  <= foff;
    chunk_length_o <= len_q;
    zero_fill_o    <= !mapped;
    last_chunk_o   <= last_q;
  end

  // word strobes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      s1_valid_q     <= cmd_i.step;
      result_valid_o <= s1_valid_q;
    end
  end

endmodule

>>> rtl/core/sparse_block_map_reader.sv
`timescale 1ns / 1ps
// Block map address translation. A load word (action 0) writes one 16-bit map
// entry; busy stays low. A read word (action 1) is cut at block boundaries of
// 2^block_shift bytes and returns one result word per chunk on consecutive
// cycles, with last_chunk on the final one. The accepted read loads position
// and length, then one chunk per cycle is cut and issues its read of the single
// map read port; each word passes the registered map read and the registered
// result. Busy stays high until the last chunk has its map data. Results are
// strobed by result_valid_o for exactly one cycle and cannot be stalled: the
// receiver must take every word as it comes. A read of length zero returns
// nothing. The user must write registers over the APB port only while the block
// is idle; the block itself does not enforce it.
module sparse_block_map_reader import sbmr_pkg::*; #(
  parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item port
  input  logic                start,
  output logic                busy,
  input  logic                action_i,
  input  logic [INDEX_W-1:0]  entry_index_i,
  input  logic [ENTRY_W-1:0]  entry_value_i,
  input  logic [DISC_W-1:0]   disc_offset_i,
  input  logic [LEN_W-1:0]    request_length_i,
  // result port
  output logic                result_valid_o,
  output logic [FOFF_W-1:0]   file_offset_o,
  output logic [LEN_W-1:0]    chunk_length_o,
  output logic                zero_fill_o,
  output logic                last_chunk_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [SHIFT_W-1:0]   block_shift_q, block_shift_d;
  logic [ENTRIES_W-1:0] map_entries_q, map_entries_d;
  logic [SHIFT_W-1:0]   wr_shift;
  logic [ENTRIES_W-1:0] wr_entries;
  logic                 cfg_wr;
  ctl_cmd_t             cmd;
  dp_stat_t             stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // clamp written values
  assign wr_shift   = (pwdata[SHIFT_W-1:0] < SHIFT_MIN) ? SHIFT_MIN :
                      (pwdata[SHIFT_W-1:0] > SHIFT_MAX) ? SHIFT_MAX :
                      pwdata[SHIFT_W-1:0];
  assign wr_entries = (32'(pwdata[ENTRIES_W-1:0]) > 32'(MAP_DEPTH)) ?
                      ENTRIES_W'(MAP_DEPTH) : pwdata[ENTRIES_W-1:0];

  // register writes
  always_comb begin
    block_shift_d = block_shift_q;
    map_entries_d = map_entries_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_BLOCK_SHIFT: block_shift_d = wr_shift;
        REG_MAP_ENTRIES: map_entries_d = wr_entries;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_shift_q <= SHIFT_RESET;
      map_entries_q <= '0;
    end else begin
      block_shift_q <= block_shift_d;
      map_entries_q <= map_entries_d;
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_SHIFT: prdata = 32'(block_shift_q);
      REG_MAP_ENTRIES: prdata = 32'(map_entries_q);
      default:         prdata = '0;
    endcase
  end

  sbmr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .action_i(action_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy    (busy)
  );

  sbmr_dpath #(
    .MAP_DEPTH(MAP_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .block_shift_i   (block_shift_q),
    .map_entries_i   (map_entries_q),
    .entry_index_i   (entry_index_i),
    .entry_value_i   (entry_value_i),
    .disc_offset_i   (disc_offset_i),
    .request_length_i(request_length_i),
    .result_valid_o  (result_valid_o),
    .file_offset_o   (file_offset_o),
    .chunk_length_o  (chunk_length_o),
    .zero_fill_o     (zero_fill_o),
    .last_chunk_o    (last_chunk_o)
  );

endmodule

>>> rtl/core/sbmr_checker.sv
`timescale 1ns / 1ps
`include "sparse_block_map_reader_macros.svh"
module sbmr_checker import sbmr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              action_i,
  input logic [LEN_W-1:0]  request_length_i,
  input logic              result_valid_o,
  input logic [FOFF_W-1:0] file_offset_o,
  input logic [LEN_W-1:0]  chunk_length_o,
  input logic              zero_fill_o
);

  // unmapped chunks carry no offset
  `SBMR_ASSERT(a_zero_fill_offset, result_valid_o && zero_fill_o, file_offset_o == '0, "zero-fill word with nonzero offset")

  // chunk length stays within a saturated request
  `SBMR_ASSERT(a_chunk_len, result_valid_o, chunk_length_o != '0 && chunk_length_o <= MAX_LEN, "chunk length out of range")

  // a nonempty read keeps the block busy in the next cycle
  `SBMR_ASSERT_NEXT(a_read_busy, start && !busy && action_i == ACT_READ && request_length_i != '0, busy, "read accepted but block not busy")

  // a load word finishes at once
  `SBMR_ASSERT_NEXT(a_load_free, start && !busy && action_i == ACT_LOAD, !busy, "load word left block busy")

  // no result word in the cycle after a load
  `SBMR_ASSERT_NEXT(a_load_quiet, start && !busy && action_i == ACT_LOAD, !result_valid_o, "result word after a load")

endmodule

bind sparse_block_map_reader sbmr_checker u_sbmr_checker (.*);
